// ===== design/oal_pkg.sv =====
// Shared types and constants for the ordered array list.
// No dependencies; imported by oal_ctrl, oal_dp and the top level.
package oal_pkg;

  // Default list capacity
  localparam int CAPACITY_DEF = 128;

  // Fixed field widths
  localparam int REQ_W = 3;
  localparam int POS_W = 8;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_GET    = 3'd2,
    REQ_MODIFY = 3'd3,
    REQ_LOCATE = 3'd4,
    REQ_CLEAR  = 3'd5
  } req_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_UP_RD,
    S_UP_WR,
    S_INS_WR,
    S_RD_POS,
    S_DN_RD,
    S_DN_WR,
    S_LOC_RD,
    S_LOC_CMP,
    S_FINISH
  } state_t;

  // Read address source
  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDX_M1,
    RD_POS_M1
  } rd_sel_t;

  // Write address and data source
  typedef enum logic [1:0] {
    WR_IDX_RDATA,
    WR_IDXM1_RDATA,
    WR_POS_VAL,
    WR_POSM1_VAL
  } wr_sel_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_FILL,
    IDX_POS,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    FILL_HOLD,
    FILL_INC,
    FILL_DEC,
    FILL_CLEAR
  } fill_op_t;

  // Controller to datapath
  typedef struct packed {
    logic     load_req;
    logic     set_stat;
    status_t  stat;
    fill_op_t fill_op;
    idx_op_t  idx_op;
    rd_sel_t  rd_sel;
    wr_sel_t  wr_sel;
    logic     we;
    logic     cap_old;
    logic     cap_found;
    logic     load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    req_t kind;
    logic pos_above_fill;
    logic pos_bad;
    logic full;
    logic empty;
    logic up_done;
    logic dn_done;
    logic scan_end;
    logic match;
  } dp_stat_t;

endpackage

// ===== design/oal_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module oal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/oal_ctrl.sv =====
// Controller state machine for the ordered array list.
// Depends on oal_pkg; drives oal_dp through cmd_t and reads dp_stat_t.
module oal_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  oal_pkg::dp_stat_t st,
  output oal_pkg::cmd_t     cmd
);
  import oal_pkg::*;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // State register and output beat flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (st.kind)
          REQ_INSERT: begin
            if (st.pos_above_fill || st.full) state_next = S_FINISH;
            else state_next = S_UP_RD;
          end
          REQ_DELETE, REQ_GET, REQ_MODIFY: begin
            if (st.pos_bad) state_next = S_FINISH;
            else state_next = S_RD_POS;
          end
          REQ_LOCATE: begin
            if (st.empty) state_next = S_FINISH;
            else state_next = S_LOC_RD;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_UP_RD: begin
        if (st.up_done) state_next = S_INS_WR;
        else state_next = S_UP_WR;
      end
      S_UP_WR:  state_next = S_UP_RD;
      S_INS_WR: state_next = S_FINISH;
      S_RD_POS: begin
        if (st.kind == REQ_DELETE) state_next = S_DN_RD;
        else state_next = S_FINISH;
      end
      S_DN_RD: begin
        if (st.dn_done) state_next = S_FINISH;
        else state_next = S_DN_WR;
      end
      S_DN_WR:  state_next = S_DN_RD;
      S_LOC_RD: state_next = S_LOC_CMP;
      S_LOC_CMP: begin
        if (st.match || st.scan_end) state_next = S_FINISH;
        else state_next = S_LOC_RD;
      end
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load_req = in_valid;
      end
      S_DECODE: begin
        case (st.kind)
          REQ_INSERT: begin
            if (st.pos_above_fill) begin
              cmd.set_stat = 1'b1;
              cmd.stat     = ST_RANGE;
            end else if (st.full) begin
              cmd.set_stat = 1'b1;
              cmd.stat     = ST_FULL;
            end else begin
              cmd.idx_op = IDX_FILL;
            end
          end
          REQ_DELETE, REQ_GET, REQ_MODIFY: begin
            if (st.pos_bad) begin
              cmd.set_stat = 1'b1;
              cmd.stat     = ST_RANGE;
            end else begin
              cmd.rd_sel = RD_POS_M1;
              cmd.idx_op = IDX_POS;
            end
          end
          REQ_LOCATE: begin
            cmd.idx_op = IDX_ZERO;
          end
          REQ_CLEAR: begin
            cmd.fill_op = FILL_CLEAR;
          end
          default: ;
        endcase
      end
      S_UP_RD: begin
        cmd.rd_sel = RD_IDX_M1;
      end
      S_UP_WR: begin
        cmd.we     = 1'b1;
        cmd.wr_sel = WR_IDX_RDATA;
        cmd.idx_op = IDX_DEC;
      end
      S_INS_WR: begin
        cmd.we      = 1'b1;
        cmd.wr_sel  = WR_POS_VAL;
        cmd.fill_op = FILL_INC;
      end
      S_RD_POS: begin
        cmd.cap_old = 1'b1;
        if (st.kind == REQ_MODIFY) begin
          cmd.we     = 1'b1;
          cmd.wr_sel = WR_POSM1_VAL;
        end
      end
      S_DN_RD: begin
        cmd.rd_sel = RD_IDX;
        if (st.dn_done) cmd.fill_op = FILL_DEC;
      end
      S_DN_WR: begin
        cmd.we     = 1'b1;
        cmd.wr_sel = WR_IDXM1_RDATA;
        cmd.idx_op = IDX_INC;
      end
      S_LOC_RD: begin
        cmd.rd_sel = RD_IDX;
      end
      S_LOC_CMP: begin
        if (st.match) cmd.cap_found = 1'b1;
        else if (!st.scan_end) cmd.idx_op = IDX_INC;
      end
      S_FINISH: begin
        cmd.load_out = out_free;
      end
      default: ;
    endcase
  end

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load_out && out_valid && !out_ready))
    else $error("result overwritten before its beat was taken");

  // A new result appears only out of the finish state
  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("result raised outside finish state");

endmodule

// ===== design/oal_dp.sv =====
// Datapath for the ordered array list: request registers, fill count,
// walk index, entry RAM and result registers. Depends on oal_pkg, oal_ram.
module oal_dp #(
  parameter int CAPACITY = oal_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  oal_pkg::cmd_t              cmd,
  output oal_pkg::dp_stat_t          st,
  input  logic [oal_pkg::REQ_W-1:0]  req_type,
  input  logic [oal_pkg::POS_W-1:0]  position,
  input  logic signed [oal_pkg::VAL_W-1:0] value,
  output logic signed [oal_pkg::VAL_W-1:0] old_value,
  output logic [oal_pkg::POS_W-1:0]  found_at,
  output logic [oal_pkg::POS_W-1:0]  count,
  output logic [oal_pkg::ST_W-1:0]   status
);
  import oal_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = AW + 1;
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  req_t             kind;
  logic [POS_W-1:0] pos;
  logic [VAL_W-1:0] val;
  logic [CW-1:0]    fill;
  logic [CW-1:0]    idx;
  logic [VAL_W-1:0] old;
  logic [POS_W-1:0] found;
  status_t          stat;

  logic [PW-1:0]    pos_x;
  logic [PW-1:0]    fill_x;
  logic [PW-1:0]    idx_x;
  logic [CW-1:0]    idx_m1;
  logic [CW-1:0]    idx_p1;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;
  logic [AW-1:0]    raddr;
  logic [VAL_W-1:0] rdata;

  assign pos_x  = PW'(pos);
  assign fill_x = PW'(fill);
  assign idx_x  = PW'(idx);
  assign idx_m1 = idx - CW'(1);
  assign idx_p1 = idx + CW'(1);

  // Status toward the controller
  always_comb begin
    st.kind           = kind;
    st.pos_above_fill = pos_x > fill_x;
    st.pos_bad        = (pos_x == '0) || (pos_x > fill_x);
    st.full           = fill >= CW'(CAPACITY);
    st.empty          = fill == '0;
    st.up_done        = idx_x <= pos_x;
    st.dn_done        = idx >= fill;
    st.scan_end       = idx_p1 >= fill;
    st.match          = rdata == val;
  end

  // Select RAM read address
  always_comb begin
    case (cmd.rd_sel)
      RD_IDX:    raddr = idx[AW-1:0];
      RD_IDX_M1: raddr = idx_m1[AW-1:0];
      RD_POS_M1: raddr = AW'(pos_x - PW'(1));
      default:   raddr = idx[AW-1:0];
    endcase
  end

  // Select RAM write address and data
  always_comb begin
    we = cmd.we;
    case (cmd.wr_sel)
      WR_IDX_RDATA: begin
        waddr = idx[AW-1:0];
        wdata = rdata;
      end
      WR_IDXM1_RDATA: begin
        waddr = idx_m1[AW-1:0];
        wdata = rdata;
      end
      WR_POS_VAL: begin
        waddr = AW'(pos_x);
        wdata = val;
      end
      WR_POSM1_VAL: begin
        waddr = AW'(pos_x - PW'(1));
        wdata = val;
      end
      default: begin
        waddr = idx[AW-1:0];
        wdata = rdata;
      end
    endcase
  end

  oal_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      case (cmd.fill_op)
        FILL_INC:   fill <= fill + CW'(1);
        FILL_DEC:   fill <= fill - CW'(1);
        FILL_CLEAR: fill <= '0;
        default:    ;
      endcase
    end
  end

  // Walk index
  always_ff @(posedge clk) begin
    case (cmd.idx_op)
      IDX_FILL: idx <= fill;
      IDX_POS:  idx <= CW'(pos_x);
      IDX_ZERO: idx <= '0;
      IDX_INC:  idx <= idx_p1;
      IDX_DEC:  idx <= idx_m1;
      default:  ;
    endcase
  end

  // Request and working result registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      kind  <= req_t'(req_type);
      pos   <= position;
      val   <= value;
      old   <= '0;
      found <= '0;
      stat  <= ST_OK;
    end else begin
      if (cmd.set_stat)  stat  <= cmd.stat;
      if (cmd.cap_old)   old   <= rdata;
      if (cmd.cap_found) found <= POS_W'(idx_p1);
    end
  end

  // Output beat registers
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      old_value <= old;
      found_at  <= found;
      count     <= POS_W'(fill);
      status    <= stat;
    end
  end

  // Count stays within capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(CAPACITY))
    else $error("fill count above capacity");

  // No write lands outside the list storage
  a_waddr_bound: assert property (@(posedge clk) disable iff (rst)
    we |-> (CW'(waddr) < CW'(CAPACITY)))
    else $error("RAM write beyond capacity");

endmodule

// ===== design/ordered_array_list.sv =====
// Ordered array list, top level: ties the controller to the datapath.
// Depends on oal_pkg, oal_ctrl, oal_dp (which holds oal_ram).
//
// Keeps an ordered list of up to CAPACITY signed 32-bit words in one RAM
// (one write port, one registered read port) plus a count, and serves one
// request at a time: a new request is taken only when the block is idle,
// while a finished result may still wait on the output. Each entry moved or
// scanned takes a read state and then a write or compare state, as the RAM
// read is registered. Insert shifts the later entries up before it writes
// the new value, delete reads the old value and then shifts the later
// entries down, get and modify read one entry (modify also writes it), and
// locate scans from the first entry until a match or the end of the list.
// A result is held back while the previous result beat still waits on the
// output. The entries need no clearing after reset.
module ordered_array_list #(
  parameter int CAPACITY = oal_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [oal_pkg::REQ_W-1:0]         req_type,
  input  logic [oal_pkg::POS_W-1:0]         position,
  input  logic signed [oal_pkg::VAL_W-1:0]  value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [oal_pkg::VAL_W-1:0]  old_value,
  output logic [oal_pkg::POS_W-1:0]         found_at,
  output logic [oal_pkg::POS_W-1:0]         count,
  output logic [oal_pkg::ST_W-1:0]          status
);
  import oal_pkg::*;

  cmd_t     cmd;
  dp_stat_t st;

  oal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  oal_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .req_type  (req_type),
    .position  (position),
    .value     (value),
    .old_value (old_value),
    .found_at  (found_at),
    .count     (count),
    .status    (status)
  );

endmodule
